FILE: rtl/core/mlt_pkg.sv
// Shared types and constants of the markup lexer tokenizer.
`timescale 1ns / 1ps

package mlt_pkg;

  // Most result items one input byte can cause.
  localparam int unsigned MaxItems = 5;
  localparam int unsigned ItemCntW = 3;

  // Default number of byte bundles between front and back.
  localparam int unsigned LexQueueDepth = 4;

  typedef enum logic [1:0] {
    ItemContent = 2'd0,
    ItemEnd     = 2'd1,
    ItemEos     = 2'd2
  } item_kind_e;

  typedef enum logic [3:0] {
    TkLine    = 4'd0,
    TkBlock   = 4'd1,
    TkGen     = 4'd2,
    TkIdent   = 4'd3,
    TkString  = 4'd4,
    TkNumber  = 4'd5,
    TkLbrace  = 4'd6,
    TkRbrace  = 4'd7,
    TkColon   = 4'd8,
    TkSemi    = 4'd9,
    TkEquals  = 4'd10,
    TkUnknown = 4'd11
  } token_kind_e;

  typedef struct packed {
    item_kind_e  kind;
    token_kind_e tk;
    logic [7:0]  data;
  } lex_item_t;

  // All items caused by one accepted byte, in order.
  typedef struct packed {
    logic [ItemCntW-1:0]          count;
    lex_item_t [MaxItems-1:0]     items;
  } lex_bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lex_q_stat_t;

endpackage

FILE: rtl/core/markup_lexer_tokenizer_unit.sv
// Top level of the streaming markup lexer tokenizer.
`timescale 1ns / 1ps

// Streaming lexer: takes one source byte per transaction (is_final_i marks the
// last byte of a text) and returns a stream of result items: content bytes
// tagged with their token kind, a token-end item after every token, and one
// end-of-stream item after the final byte. The front end accepts one byte
// every cycle while the bundle queue has room; each byte yields zero to five
// items, packed into one bundle. The back end drains the queue at one item
// per cycle while the output is not stalled, so the sustained rate is one
// byte per cycle when bytes average at most one item each, and the back end
// sets the pace otherwise; the queue (QueueDepth bundles) absorbs bursts
// such as token ends and closes at the final byte. Whitespace in idle mode
// yields no item. Items pass the queue memory, then a registered output.
// There is no configuration; reset returns to idle between tokens.

module markup_lexer_tokenizer_unit import mlt_pkg::*; #(
  parameter int unsigned QueueDepth = LexQueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       is_final_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] item_kind_o,
  output logic [3:0] token_kind_o,
  output logic [7:0] out_byte_o
);

  logic        push, pop;
  lex_bundle_t bundle_in, bundle_head;
  lex_q_stat_t q_stat;

  // Classify each byte and advance the lexer mode.
  mlt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .is_final_i (is_final_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .bundle_o   (bundle_in)
  );

  // Hold bundles so either side can stall on its own.
  mlt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (bundle_in),
    .pop_i    (pop),
    .head_o   (bundle_head),
    .stat_o   (q_stat)
  );

  // Emit the items of each bundle in order.
  mlt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (bundle_head),
    .q_stat_i     (q_stat),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .item_kind_o  (item_kind_o),
    .token_kind_o (token_kind_o),
    .out_byte_o   (out_byte_o)
  );

endmodule

FILE: rtl/core/mlt_front.sv
// Front end: accepts source bytes, tracks lexer mode, builds result bundles.
`timescale 1ns / 1ps

module mlt_front import mlt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        is_final_i,
  input  lex_q_stat_t q_stat_i,
  output logic        push_o,
  output lex_bundle_t bundle_o
);

  typedef enum logic [6:0] {
    ModeIdle   = 7'b0000001,
    ModeLine   = 7'b0000010,
    ModeBlock  = 7'b0000100,
    ModeGen    = 7'b0001000,
    ModeIdent  = 7'b0010000,
    ModeNumber = 7'b0100000,
    ModeString = 7'b1000000
  } mode_e;

  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChLbrace = 8'h7B;
  localparam logic [7:0] ChRbrace = 8'h7D;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChEquals = 8'h3D;
  localparam logic [7:0] ChUnder  = 8'h5F;
  localparam int unsigned NumSlots = 8;

  function automatic logic is_ws(logic [7:0] b);
    return b == ChSpace || b == 8'h09 || b == ChLf || b == 8'h0B || b == 8'h0C || b == 8'h0D;
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic token_kind_e mode_kind(mode_e m);
    token_kind_e tk;
    case (m)
      ModeLine:   tk = TkLine;
      ModeBlock:  tk = TkBlock;
      ModeGen:    tk = TkGen;
      ModeIdent:  tk = TkIdent;
      ModeNumber: tk = TkNumber;
      default:    tk = TkString;
    endcase
    return tk;
  endfunction

  function automatic lex_item_t mk_item(item_kind_e k, token_kind_e tk, logic [7:0] d);
    lex_item_t it;
    it.kind = k;
    it.tk   = tk;
    it.data = d;
    return it;
  endfunction

  mode_e      mode_q, mode_d;
  logic [7:0] held_q, held_d;
  logic       hv_q, hv_d;
  logic       qs_q, qs_d;

  logic accept;
  assign accept     = in_valid_i && !q_stat_i.full;
  assign in_stall_o = q_stat_i.full;

  // Classification of the byte as a token start.
  mode_e       fi_mode;
  logic        fi_hold;
  logic        fi_str;
  logic [1:0]  fi_n;
  token_kind_e fi_tk;

  always_comb begin
    fi_mode = ModeIdle;
    fi_hold = 1'b0;
    fi_str  = 1'b0;
    fi_n    = 2'd0;
    fi_tk   = TkUnknown;
    if (is_ws(in_byte_i)) begin
      fi_n = 2'd0;
    end else if (in_byte_i == ChSlash || in_byte_i == ChHash) begin
      fi_hold = 1'b1;
    end else if (is_alpha(in_byte_i) || in_byte_i == ChUnder) begin
      fi_mode = ModeIdent;
      fi_n    = 2'd1;
      fi_tk   = TkIdent;
    end else if (in_byte_i == ChDquote || in_byte_i == ChSquote) begin
      fi_mode = ModeString;
      fi_str  = 1'b1;
    end else if (is_digit(in_byte_i)) begin
      fi_mode = ModeNumber;
      fi_n    = 2'd1;
      fi_tk   = TkNumber;
    end else begin
      fi_n = 2'd2;
      case (in_byte_i)
        ChLbrace: fi_tk = TkLbrace;
        ChRbrace: fi_tk = TkRbrace;
        ChColon:  fi_tk = TkColon;
        ChSemi:   fi_tk = TkSemi;
        ChEquals: fi_tk = TkEquals;
        default:  fi_tk = TkUnknown;
      endcase
    end
  end

  // Slots: 0,1 mode step; 2,3 token start; 4..6 close at final byte; 7 end of stream.
  lex_item_t           slot [NumSlots];
  logic [NumSlots-1:0] slot_en;
  logic                use_fi;
  lex_bundle_t         bundle;
  logic [ItemCntW-1:0] cnt;

  always_comb begin
    mode_d  = mode_q;
    held_d  = held_q;
    hv_d    = hv_q;
    qs_d    = qs_q;
    use_fi  = 1'b0;
    slot_en = '0;
    for (int i = 0; i < NumSlots; i++) begin
      slot[i] = '0;
    end

    case (mode_q)
      ModeLine, ModeGen: begin
        if (in_byte_i == ChLf) begin
          slot_en[0] = 1'b1;
          slot[0]    = mk_item(ItemEnd, mode_kind(mode_q), 8'h00);
          mode_d     = ModeIdle;
        end else begin
          slot_en[0] = 1'b1;
          slot[0]    = mk_item(ItemContent, mode_kind(mode_q), in_byte_i);
        end
      end
      ModeBlock: begin
        if (hv_q) begin
          if (in_byte_i == ChSlash) begin
            hv_d       = 1'b0;
            held_d     = 8'h00;
            slot_en[0] = 1'b1;
            slot[0]    = mk_item(ItemEnd, TkBlock, 8'h00);
            mode_d     = ModeIdle;
          end else if (in_byte_i == ChStar) begin
            slot_en[0] = 1'b1;
            slot[0]    = mk_item(ItemContent, TkBlock, ChStar);
          end else begin
            hv_d       = 1'b0;
            held_d     = 8'h00;
            slot_en[1:0] = 2'b11;
            slot[0]    = mk_item(ItemContent, TkBlock, ChStar);
            slot[1]    = mk_item(ItemContent, TkBlock, in_byte_i);
          end
        end else if (in_byte_i == ChStar) begin
          held_d = in_byte_i;
          hv_d   = 1'b1;
        end else begin
          slot_en[0] = 1'b1;
          slot[0]    = mk_item(ItemContent, TkBlock, in_byte_i);
        end
      end
      ModeIdent: begin
        slot_en[0] = 1'b1;
        if (is_alpha(in_byte_i) || is_digit(in_byte_i) || in_byte_i == ChUnder) begin
          slot[0] = mk_item(ItemContent, TkIdent, in_byte_i);
        end else begin
          slot[0] = mk_item(ItemEnd, TkIdent, 8'h00);
          use_fi  = 1'b1;
        end
      end
      ModeNumber: begin
        slot_en[0] = 1'b1;
        if (is_digit(in_byte_i)) begin
          slot[0] = mk_item(ItemContent, TkNumber, in_byte_i);
        end else begin
          slot[0] = mk_item(ItemEnd, TkNumber, 8'h00);
          use_fi  = 1'b1;
        end
      end
      ModeString: begin
        slot_en[0] = 1'b1;
        if (in_byte_i == (qs_q ? ChSquote : ChDquote)) begin
          slot[0] = mk_item(ItemEnd, TkString, 8'h00);
          mode_d  = ModeIdle;
          qs_d    = 1'b0;
        end else begin
          slot[0] = mk_item(ItemContent, TkString, in_byte_i);
        end
      end
      default: begin
        if (hv_q) begin
          hv_d   = 1'b0;
          held_d = 8'h00;
          if (held_q == ChSlash && in_byte_i == ChSlash) begin
            mode_d = ModeLine;
          end else if (held_q == ChSlash && in_byte_i == ChStar) begin
            mode_d = ModeBlock;
          end else if (held_q == ChHash && in_byte_i == ChSpace) begin
            mode_d = ModeGen;
          end else begin
            slot_en[1:0] = 2'b11;
            slot[0]      = mk_item(ItemContent, TkUnknown, held_q);
            slot[1]      = mk_item(ItemEnd, TkUnknown, 8'h00);
            use_fi       = 1'b1;
          end
        end else begin
          use_fi = 1'b1;
        end
      end
    endcase

    // Start a new token from idle.
    if (use_fi) begin
      mode_d = fi_mode;
      if (fi_hold) begin
        held_d = in_byte_i;
        hv_d   = 1'b1;
      end
      if (fi_str) begin
        qs_d = (in_byte_i == ChSquote);
      end
      slot_en[2] = (fi_n != 2'd0);
      slot_en[3] = (fi_n == 2'd2);
      slot[2]    = mk_item(ItemContent, fi_tk, in_byte_i);
      slot[3]    = mk_item(ItemEnd, fi_tk, 8'h00);
    end

    // Close whatever is open at the final byte, then return to reset state.
    if (is_final_i) begin
      if (mode_d == ModeIdle) begin
        if (hv_d) begin
          slot_en[5] = 1'b1;
          slot_en[6] = 1'b1;
          slot[5]    = mk_item(ItemContent, TkUnknown, held_d);
          slot[6]    = mk_item(ItemEnd, TkUnknown, 8'h00);
        end
      end else begin
        if (mode_d == ModeBlock && hv_d) begin
          slot_en[4] = 1'b1;
          slot[4]    = mk_item(ItemContent, TkBlock, ChStar);
        end
        slot_en[5] = 1'b1;
        slot[5]    = mk_item(ItemEnd, mode_kind(mode_d), 8'h00);
      end
      slot_en[7] = 1'b1;
      slot[7]    = mk_item(ItemEos, TkLine, 8'h00);
      mode_d     = ModeIdle;
      held_d     = 8'h00;
      hv_d       = 1'b0;
      qs_d       = 1'b0;
    end

    // Pack the enabled slots in order, dropping any beyond the bundle size.
    bundle = '0;
    cnt    = '0;
    for (int i = 0; i < NumSlots; i++) begin
      if (slot_en[i] && cnt < ItemCntW'(MaxItems)) begin
        bundle.items[cnt] = slot[i];
        cnt = cnt + 1'b1;
      end
    end
    bundle.count = cnt;
  end

  assign bundle_o = bundle;
  assign push_o   = accept && (cnt != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      held_q <= 8'h00;
      hv_q   <= 1'b0;
      qs_q   <= 1'b0;
    end else if (accept) begin
      mode_q <= mode_d;
      held_q <= held_d;
      hv_q   <= hv_d;
      qs_q   <= qs_d;
    end
  end

endmodule

FILE: rtl/core/mlt_queue.sv
// Bundle queue between the lexer front end and the item back end.
`timescale 1ns / 1ps

module mlt_queue import mlt_pkg::*; #(
  parameter int unsigned Depth = LexQueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  lex_bundle_t bundle_i,
  input  logic        pop_i,
  output lex_bundle_t head_o,
  output lex_q_stat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  lex_bundle_t     mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= bundle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: rtl/core/mlt_back.sv
// Back end: walks the head bundle and drives one result item per cycle while the output is not stalled.
`timescale 1ns / 1ps

module mlt_back import mlt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  lex_bundle_t head_i,
  input  lex_q_stat_t q_stat_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  item_kind_o,
  output logic [3:0]  token_kind_o,
  output logic [7:0]  out_byte_o
);

  logic [ItemCntW-1:0] idx_q, idx_d;
  logic                valid_q, valid_d;
  lex_item_t           item_q;
  logic                load, last;

  // Load the next item when the output register is free or being taken.
  assign load  = !q_stat_i.empty && (!valid_q || !out_stall_i);
  assign last  = (idx_q == ItemCntW'(head_i.count - 1'b1));
  assign pop_o = load && last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      idx_d   = last ? '0 : idx_q + 1'b1;
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= head_i.items[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign item_kind_o  = item_q.kind;
  assign token_kind_o = item_q.tk;
  assign out_byte_o   = item_q.data;

endmodule

FILE: sim/tb_markup_lexer_tokenizer_unit.sv
// Self-checking testbench for the markup lexer tokenizer unit.
`timescale 1ns / 1ps

module tb_markup_lexer_tokenizer_unit;
  import mlt_pkg::*;

  // Lexer scan modes tracked by the predictor.
  typedef enum logic [2:0] {
    ScanIdle,
    ScanLine,
    ScanBlock,
    ScanGen,
    ScanIdent,
    ScanNumber,
    ScanString
  } scan_mode_e;

  // One row of the directed table. Rows with typed set carry their expected
  // items inline; the others are predicted.
  typedef struct packed {
    logic [7:0] b;
    logic       fin;
    logic       typed;
    logic [1:0] n;
    lex_item_t  e0;
    lex_item_t  e1;
    lex_item_t  e2;
  } stim_row_t;

  localparam lex_item_t NoItem = '0;
  localparam logic [7:0] Lf = 8'h0A;
  localparam int unsigned RandomBytes = 375;

  localparam string IdStart = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  localparam string IdCont  = "abcxyzABCXYZ_0123456789";

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] in_byte_i;
  logic       is_final_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [1:0] item_kind_o;
  logic [3:0] token_kind_o;
  logic [7:0] out_byte_o;

  // Predictor state.
  scan_mode_e scan_mode;
  logic [7:0] look_byte;
  logic       look_valid;
  logic       quote_is_single;

  lex_item_t  step_items[$];      // items caused by the byte just accepted
  lex_item_t  expected_items[$];  // items still owed by the block, oldest first
  stim_row_t  stim_table[$];
  logic [7:0] text_bytes[$];
  lex_item_t  want;
  int         fail_count;
  int unsigned idle_max;          // longest gap or stall drawn per transaction

  markup_lexer_tokenizer_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .is_final_i   (is_final_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .item_kind_o  (item_kind_o),
    .token_kind_o (token_kind_o),
    .out_byte_o   (out_byte_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Character classes and item helpers
  // ---------------------------------------------------------------------

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0B || c == 8'h0C || c == 8'h0D;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic lex_item_t itm(input item_kind_e k, input token_kind_e t,
                                    input logic [7:0] d);
    return {k, t, d};
  endfunction

  function automatic token_kind_e mode_token(input scan_mode_e m);
    case (m)
      ScanLine:   return TkLine;
      ScanBlock:  return TkBlock;
      ScanGen:    return TkGen;
      ScanIdent:  return TkIdent;
      ScanNumber: return TkNumber;
      default:    return TkString;
    endcase
  endfunction

  function automatic token_kind_e single_kind(input logic [7:0] c);
    case (c)
      "{":     return TkLbrace;
      "}":     return TkRbrace;
      ":":     return TkColon;
      ";":     return TkSemi;
      "=":     return TkEquals;
      default: return TkUnknown;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  task automatic clear_scan_state();
    scan_mode       = ScanIdle;
    look_byte       = 8'h00;
    look_valid      = 1'b0;
    quote_is_single = 1'b0;
  endtask

  task automatic emit(input item_kind_e k, input token_kind_e t, input logic [7:0] d);
    if (step_items.size() < MaxItems) step_items.insert(step_items.size(), itm(k, t, d));
  endtask

  // A one-byte token: its content item and its end item.
  task automatic emit_single(input token_kind_e t, input logic [7:0] c);
    emit(ItemContent, t, c);
    emit(ItemEnd, t, 8'h00);
  endtask

  // Start a new token with c, nothing held.
  task automatic start_token(input logic [7:0] c);
    scan_mode = ScanIdle;
    if (is_space(c)) return;
    if (c == "/" || c == "#") begin
      look_byte  = c;
      look_valid = 1'b1;
    end else if (is_letter(c) || c == "_") begin
      scan_mode = ScanIdent;
      emit(ItemContent, TkIdent, c);
    end else if (c == "\"" || c == "'") begin
      scan_mode       = ScanString;
      quote_is_single = (c == "'");
    end else if (is_digit(c)) begin
      scan_mode = ScanNumber;
      emit(ItemContent, TkNumber, c);
    end else begin
      emit_single(single_kind(c), c);
    end
  endtask

  // Advance the predictor by one accepted byte; step_items gets its items.
  task automatic lex_byte(input logic [7:0] c, input logic fin);
    logic [7:0] held;
    step_items.delete();
    case (scan_mode)
      ScanLine, ScanGen: begin
        if (c == Lf) begin
          emit(ItemEnd, mode_token(scan_mode), 8'h00);
          scan_mode = ScanIdle;
        end else begin
          emit(ItemContent, mode_token(scan_mode), c);
        end
      end
      ScanBlock: begin
        if (look_valid) begin
          if (c == "/") begin
            look_valid = 1'b0;
            look_byte  = 8'h00;
            emit(ItemEnd, TkBlock, 8'h00);
            scan_mode = ScanIdle;
          end else if (c == "*") begin
            emit(ItemContent, TkBlock, "*");
          end else begin
            look_valid = 1'b0;
            look_byte  = 8'h00;
            emit(ItemContent, TkBlock, "*");
            emit(ItemContent, TkBlock, c);
          end
        end else if (c == "*") begin
          look_byte  = c;
          look_valid = 1'b1;
        end else begin
          emit(ItemContent, TkBlock, c);
        end
      end
      ScanIdent: begin
        if (is_letter(c) || is_digit(c) || c == "_") begin
          emit(ItemContent, TkIdent, c);
        end else begin
          emit(ItemEnd, TkIdent, 8'h00);
          start_token(c);
        end
      end
      ScanNumber: begin
        if (is_digit(c)) begin
          emit(ItemContent, TkNumber, c);
        end else begin
          emit(ItemEnd, TkNumber, 8'h00);
          start_token(c);
        end
      end
      ScanString: begin
        if (c == (quote_is_single ? 8'h27 : 8'h22)) begin
          emit(ItemEnd, TkString, 8'h00);
          scan_mode       = ScanIdle;
          quote_is_single = 1'b0;
        end else begin
          emit(ItemContent, TkString, c);
        end
      end
      default: begin
        if (look_valid) begin
          held       = look_byte;
          look_valid = 1'b0;
          look_byte  = 8'h00;
          if (held == "/" && c == "/") begin
            scan_mode = ScanLine;
          end else if (held == "/" && c == "*") begin
            scan_mode = ScanBlock;
          end else if (held == "#" && c == " ") begin
            scan_mode = ScanGen;
          end else begin
            emit_single(TkUnknown, held);
            start_token(c);
          end
        end else begin
          start_token(c);
        end
      end
    endcase

    // Close whatever is open at the final byte, then mark end of stream.
    if (fin) begin
      if (scan_mode == ScanIdle) begin
        if (look_valid) emit_single(TkUnknown, look_byte);
      end else begin
        if (scan_mode == ScanBlock && look_valid) emit(ItemContent, TkBlock, "*");
        emit(ItemEnd, mode_token(scan_mode), 8'h00);
      end
      // token kind reads as zero in the end-of-stream item
      emit(ItemEos, TkLine, 8'h00);
      clear_scan_state();
    end
  endtask

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------

  // Drive one byte after a random gap and hold it until the block takes it.
  // On acceptance, run the predictor and, if asked, queue its items.
  task automatic send_byte(input logic [7:0] c, input logic fin, input logic use_pred);
    int unsigned gap;
    gap = $urandom_range(0, idle_max);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_byte_i  <= c;
    is_final_i <= fin;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    lex_byte(c, fin);
    if (use_pred) begin
      foreach (step_items[k]) expected_items.insert(expected_items.size(), step_items[k]);
    end
  endtask

  // Drop valid and hold off until every owed item has come out.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_items.size() != 0) @(posedge clk_i);
  endtask

  task automatic row_pred(input logic [7:0] c, input logic fin);
    stim_table.insert(stim_table.size(), {c, fin, 1'b0, 2'd0, NoItem, NoItem, NoItem});
  endtask

  task automatic row_typed(input logic [7:0] c, input logic fin, input logic [1:0] n,
                           input lex_item_t e0, input lex_item_t e1, input lex_item_t e2);
    stim_table.insert(stim_table.size(), {c, fin, 1'b1, n, e0, e1, e2});
  endtask

  // ---------------------------------------------------------------------
  // Random text generation
  // ---------------------------------------------------------------------

  function automatic logic [7:0] pick(input string pool);
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  function automatic logic [7:0] space_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h20;
      1:       return 8'h09;
      2:       return 8'h0A;
      3:       return 8'h0B;
      4:       return 8'h0C;
      default: return 8'h0D;
    endcase
  endfunction

  // Body byte for strings and comments: text, delimiters, whitespace or noise, in equal shares.
  function automatic logic [7:0] rich_byte();
    case ($urandom_range(0, 3))
      0:       return pick(IdCont);
      1:       return pick("\"'*/# ");
      2:       return space_byte();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Append one byte to the text being built.
  task automatic add_byte(input logic [7:0] b);
    text_bytes.insert(text_bytes.size(), b);
  endtask

  task automatic add_fragment(input int unsigned sel);
    logic [7:0] q;
    logic [7:0] c;
    case (sel)
      0: begin
        add_byte(pick(IdStart));
        repeat ($urandom_range(0, 5)) add_byte(pick(IdCont));
      end
      1: repeat ($urandom_range(1, 4)) add_byte(pick("0123456789"));
      2: begin
        q = $urandom_range(0, 1) ? 8'h27 : 8'h22;
        add_byte(q);
        repeat ($urandom_range(0, 5)) begin
          c = rich_byte();
          if (c != q) add_byte(c);
        end
        add_byte(q);
      end
      3, 4: begin
        add_byte(sel == 3 ? "/" : "#");
        add_byte(sel == 3 ? "/" : " ");
        repeat ($urandom_range(0, 5)) begin
          c = rich_byte();
          if (c != Lf) add_byte(c);
        end
        add_byte(Lf);
      end
      5: begin
        add_byte("/");
        add_byte("*");
        repeat ($urandom_range(0, 6)) add_byte(pick("ab*/ *\n"));
        add_byte("*");
        add_byte("/");
      end
      6: add_byte(pick("{}:;="));
      7: repeat ($urandom_range(1, 3)) add_byte(space_byte());
      8: add_byte(8'($urandom_range(0, 255)));
      9: add_byte(pick("/#"));
      10: add_byte("*");
      default: add_byte(" ");
    endcase
  endtask

  // Build one text of random fragments, now and then cut short so that
  // the final byte can land inside a token.
  task automatic make_text();
    int unsigned cut;
    text_bytes.delete();
    repeat ($urandom_range(3, 12)) add_fragment($urandom_range(0, 11));
    if ($urandom_range(0, 3) == 0) begin
      cut = $urandom_range(1, text_bytes.size());
      while (text_bytes.size() > cut) void'(text_bytes.pop_back());
    end
  endtask

  // ---------------------------------------------------------------------
  // Output side: random stall per transaction, check every accepted item
  // ---------------------------------------------------------------------

  initial begin
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      repeat ($urandom_range(0, idle_max)) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_items.size() == 0) begin
        $error("unexpected item: item_kind %0d token_kind %0d out_byte %02h",
               item_kind_o, token_kind_o, out_byte_o);
        fail_count++;
      end else begin
        want = expected_items.pop_front();
        if (item_kind_o !== want.kind) begin
          $error("item_kind: expected %0d, actual %0d", want.kind, item_kind_o);
          fail_count++;
        end
        if (token_kind_o !== want.tk) begin
          $error("token_kind: expected %0d, actual %0d", want.tk, token_kind_o);
          fail_count++;
        end
        if (out_byte_o !== want.data) begin
          $error("out_byte: expected %02h, actual %02h", want.data, out_byte_o);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  initial begin
    stim_row_t   cur_row;
    int unsigned sent_count;
    logic        paused;
    logic [7:0]  c;
    logic        fin;

    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_byte_i  = 8'h00;
    is_final_i = 1'b0;
    fail_count = 0;
    idle_max   = 4;
    sent_count = 0;
    paused     = 1'b0;
    clear_scan_state();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: byte extremes, high byte, single-byte tokens but '=' and
    // stray star typed in, and a held hash at the final byte; token boundaries,
    // lone hash, comments, strings and other final-byte closes are predicted.
    row_typed(8'h00, 1'b0, 2'd2, itm(ItemContent, TkUnknown, 8'h00),
              itm(ItemEnd, TkUnknown, 8'h00), NoItem);
    row_typed(8'h80, 1'b0, 2'd2, itm(ItemContent, TkUnknown, 8'h80),
              itm(ItemEnd, TkUnknown, 8'h00), NoItem);
    row_typed(8'hFF, 1'b0, 2'd2, itm(ItemContent, TkUnknown, 8'hFF),
              itm(ItemEnd, TkUnknown, 8'h00), NoItem);
    row_typed("{", 1'b0, 2'd2, itm(ItemContent, TkLbrace, "{"),
              itm(ItemEnd, TkLbrace, 8'h00), NoItem);
    row_typed("}", 1'b0, 2'd2, itm(ItemContent, TkRbrace, "}"),
              itm(ItemEnd, TkRbrace, 8'h00), NoItem);
    row_typed(":", 1'b0, 2'd2, itm(ItemContent, TkColon, ":"),
              itm(ItemEnd, TkColon, 8'h00), NoItem);
    row_typed(";", 1'b0, 2'd2, itm(ItemContent, TkSemi, ";"),
              itm(ItemEnd, TkSemi, 8'h00), NoItem);
    row_typed("*", 1'b0, 2'd2, itm(ItemContent, TkUnknown, "*"),
              itm(ItemEnd, TkUnknown, 8'h00), NoItem);
    row_typed(8'h09, 1'b0, 2'd0, NoItem, NoItem, NoItem);
    // identifier ended by '=', number ended by a letter
    row_pred("a", 1'b0);
    row_pred("=", 1'b0);
    row_pred("4", 1'b0);
    row_pred("x", 1'b0);
    // lone hash, then a generator comment closed by LF
    row_pred("#", 1'b0);
    row_pred("q", 1'b0);
    row_pred("#", 1'b0);
    row_pred(" ", 1'b0);
    row_pred(8'hAA, 1'b0);
    row_pred(Lf, 1'b0);
    // single-quoted string holding a double quote
    row_pred("'", 1'b0);
    row_pred("\"", 1'b0);
    row_pred("'", 1'b0);
    // block comment: slash right after the opener, doubled star before close
    row_pred("/", 1'b0);
    row_pred("*", 1'b0);
    row_pred("/", 1'b0);
    row_pred("*", 1'b0);
    row_pred("*", 1'b0);
    row_pred("/", 1'b0);
    // line comment left open at the final byte
    row_pred("/", 1'b0);
    row_pred("/", 1'b0);
    row_pred("z", 1'b1);
    // held hash at the final byte
    row_typed("#", 1'b1, 2'd3, itm(ItemContent, TkUnknown, "#"),
              itm(ItemEnd, TkUnknown, 8'h00), itm(ItemEos, TkLine, 8'h00));
    // held star inside an open block comment at the final byte
    row_pred("/", 1'b0);
    row_pred("*", 1'b0);
    row_pred("*", 1'b1);

    foreach (stim_table[i]) begin
      cur_row = stim_table[i];
      send_byte(cur_row.b, cur_row.fin, !cur_row.typed);
      if (cur_row.typed) begin
        if (cur_row.n > 0) expected_items.insert(expected_items.size(), cur_row.e0);
        if (cur_row.n > 1) expected_items.insert(expected_items.size(), cur_row.e1);
        if (cur_row.n > 2) expected_items.insert(expected_items.size(), cur_row.e2);
      end
    end
    drain_results();

    // Random texts. Each ends with its final byte, so the lexer is back at
    // idle between texts. Idle-free stretches come and go per text.
    while (sent_count < RandomBytes) begin
      make_text();
      idle_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
      foreach (text_bytes[i]) begin
        c   = text_bytes[i];
        fin = (i == text_bytes.size() - 1);
        send_byte(c, fin, 1'b1);
        sent_count++;
      end
      // Hold off once mid-run until the output side has caught up.
      if (!paused && sent_count > RandomBytes / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && expected_items.size() == 0) begin
      $display("markup_lexer_tokenizer_unit regression: pass");
    end else begin
      $display("markup_lexer_tokenizer_unit regression: fail");
    end
    $finish;
  end

  // Run limit: far beyond the slowest correct run.
  initial begin
    #1000000;
    $display("markup_lexer_tokenizer_unit regression: fail");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/mlt_pkg.sv
rtl/core/mlt_front.sv
rtl/core/mlt_queue.sv
rtl/core/mlt_back.sv
rtl/core/markup_lexer_tokenizer_unit.sv
sim/tb_markup_lexer_tokenizer_unit.sv
